/* design/rstt_pkg.sv */
package rstt_pkg;

    typedef logic [3:0]        t_op;
    typedef logic [2:0]        t_event;
    typedef logic signed [5:0] t_reg_field;
    typedef logic [4:0]        t_reg_idx;
    typedef logic [31:0]       t_mask;
    typedef logic signed [63:0] t_offset;

    localparam t_op OP_ADD   = 4'd0;
    localparam t_op OP_SUB   = 4'd1;
    localparam t_op OP_MOV   = 4'd2;
    localparam t_op OP_LDR   = 4'd3;
    localparam t_op OP_STR   = 4'd4;
    localparam t_op OP_B     = 4'd5;
    localparam t_op OP_BL    = 4'd6;
    localparam t_op OP_RET   = 4'd7;
    localparam t_op OP_CBZ   = 4'd8;
    localparam t_op OP_CBNZ  = 4'd9;
    localparam t_op OP_OTHER = 4'd10;

    localparam t_event EV_NONE    = 3'd0;
    localparam t_event EV_SOURCE  = 3'd1;
    localparam t_event EV_STORE   = 3'd2;
    localparam t_event EV_LOAD    = 3'd3;
    localparam t_event EV_SPREAD  = 3'd4;
    localparam t_event EV_SINK    = 3'd5;
    localparam t_event EV_GENERIC = 3'd6;

endpackage

/* design/rstt_if.sv */
interface rstt_in_if;
    import rstt_pkg::*;

    logic       valid;
    logic       ready;
    t_op        op;
    t_reg_field dst_reg;
    t_reg_field src_a_reg;
    t_reg_field src_b_reg;
    t_offset    stack_offset;
    logic       source_call;
    logic       begin_run;

    modport source (
        output valid, op, dst_reg, src_a_reg, src_b_reg, stack_offset,
               source_call, begin_run,
        input  ready
    );
    modport sink (
        input  valid, op, dst_reg, src_a_reg, src_b_reg, stack_offset,
               source_call, begin_run,
        output ready
    );
endinterface

interface rstt_out_if;
    import rstt_pkg::*;

    logic     valid;
    logic     ready;
    t_event   event_kind;
    t_reg_idx newly_tainted_reg;
    t_mask    taint_mask;
    logic     sink_seen;
    logic     offset_store_full;

    modport source (
        output valid, event_kind, newly_tainted_reg, taint_mask, sink_seen,
               offset_store_full,
        input  ready
    );
    modport sink (
        input  valid, event_kind, newly_tainted_reg, taint_mask, sink_seen,
               offset_store_full,
        output ready
    );
endinterface

/* design/register_stack_taint_tracker.sv */
// Channel   Dir  Modport      Word
// i_in      in   sink         one lifted instruction (op, regs, offset, flags)
// o_out     out  source       one taint result (event, new reg, mask, flags)
//
// Steps: each item is taken in the idle state, its offset is compared against the
// stored stack offsets (at most STACK_SLOTS) by walking the offset memory through
// its single registered read port, and a finish step hands over the result.
// Reset (i_rst_n low, synchronous) clears the mask, the offset count, the sink
// flag and the handshakes; the offset memory is not cleared.
// A stalled result is held in the output register; the next word is taken
// meanwhile, and the finish step waits until the output register is free.
module register_stack_taint_tracker #(
    parameter int STACK_SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rstt_in_if.sink           i_in,
    rstt_out_if.source        o_out
);
    import rstt_pkg::*;

    // Index and fill-count widths follow the slot count.
    localparam int IW = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
    localparam int CW = $clog2(STACK_SLOTS + 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]   r_state, n_state;

    // Architectural taint state.
    t_mask        r_mask;
    logic [CW-1:0] r_count;
    logic         r_sink;

    // Offset memory, undefined until written.
    t_offset      r_mem [STACK_SLOTS];
    t_offset      r_rd_data;

    // Held instruction word.
    t_op          r_op;
    t_reg_field   r_dst;
    t_reg_field   r_sa;
    t_reg_field   r_sb;
    t_offset      r_off;
    logic         r_src_call;

    // Scan control.
    logic [CW-1:0] r_rd_idx;
    logic         r_cmp_vld;
    logic         r_hit;

    // Output register.
    logic         r_o_valid;
    t_event       r_o_ev;
    t_reg_idx     r_o_reg;
    t_mask        r_o_mask;
    logic         r_o_sink;
    logic         r_o_full;

    logic         in_fire;
    logic         out_free;
    logic         rd_en;
    logic         finish;

    // Finish-step results.
    t_event       ev;
    t_reg_idx     newreg;
    t_mask        n_mask;
    logic         n_sink;
    logic         dropped;
    logic         wr_en;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_o_valid || o_out.ready;
    assign rd_en      = (r_state == S_SCAN) && (r_rd_idx < r_count);
    assign finish     = (r_state == S_DONE) && out_free;

    function automatic logic reg_ok(input t_reg_field f);
        return !f[5];
    endfunction

    function automatic logic reg_hot(input t_reg_field f, input t_mask m);
        return !f[5] && m[f[4:0]];
    endfunction

    // Sequencer: take word, walk offsets, finish.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Leave once every stored offset has been issued and compared.
                if (r_rd_idx == r_count) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Work out event and new state from the held word and the scan result.
    always_comb begin
        ev       = EV_NONE;
        newreg   = '0;
        n_mask   = r_mask;
        n_sink   = r_sink;
        dropped  = 1'b0;
        wr_en    = 1'b0;
        case (r_op)
            OP_BL: begin
                if (r_src_call) begin
                    n_mask[0] = 1'b1;
                    ev = EV_SOURCE;
                end
            end
            OP_STR: begin
                if (reg_hot(r_dst, r_mask)) begin
                    ev = EV_STORE;
                    if (!r_hit) begin
                        if (r_count < CW'(STACK_SLOTS)) begin
                            wr_en = 1'b1;
                        end else begin
                            dropped = 1'b1;
                        end
                    end
                end
            end
            OP_LDR: begin
                if (reg_ok(r_dst) && r_hit) begin
                    newreg = r_dst[4:0];
                    n_mask[r_dst[4:0]] = 1'b1;
                    ev = EV_LOAD;
                end
            end
            OP_ADD, OP_SUB, OP_MOV: begin
                if (reg_ok(r_dst) && (reg_hot(r_sa, r_mask) || reg_hot(r_sb, r_mask))) begin
                    newreg = r_dst[4:0];
                    n_mask[r_dst[4:0]] = 1'b1;
                    ev = EV_SPREAD;
                end
            end
            OP_RET: begin
                if (r_mask[0]) begin
                    n_sink = 1'b1;
                    ev = EV_SINK;
                end
            end
            OP_OTHER: begin
                if (reg_ok(r_dst) && reg_hot(r_sa, r_mask)) begin
                    newreg = r_dst[4:0];
                    n_mask[r_dst[4:0]] = 1'b1;
                    ev = EV_GENERIC;
                end
            end
            default: begin
                ev = EV_NONE;
            end
        endcase
    end

    // Offset memory: one read port for the walk, one write for inserts.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_idx[IW-1:0]];
        end
        if (finish && wr_en) begin
            r_mem[r_count[IW-1:0]] <= r_off;
        end
    end

    // Hold the word while it is worked on.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op       <= i_in.op;
            r_dst      <= i_in.dst_reg;
            r_sa       <= i_in.src_a_reg;
            r_sb       <= i_in.src_b_reg;
            r_off      <= i_in.stack_offset;
            r_src_call <= i_in.source_call;
        end
        if (finish) begin
            r_o_ev   <= ev;
            r_o_reg  <= newreg;
            r_o_mask <= n_mask;
            r_o_sink <= n_sink;
            r_o_full <= dropped;
        end
    end

    // Control and taint state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mask    <= '0;
            r_count   <= '0;
            r_sink    <= 1'b0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Load a new result on finish, else drop it once the sink takes it.
            if (finish) begin
                r_o_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_o_valid <= 1'b0;
            end

            if (in_fire) begin
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
                r_hit     <= 1'b0;
                // Begin flag: clear all taint state ahead of this word.
                if (i_in.begin_run) begin
                    r_mask  <= '0;
                    r_count <= '0;
                    r_sink  <= 1'b0;
                end
            end

            if (r_state == S_SCAN) begin
                // Issue one slot read per cycle, compare it the cycle after.
                if (rd_en) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
                r_cmp_vld <= rd_en;
                if (r_cmp_vld && (r_rd_data == r_off)) begin
                    r_hit <= 1'b1;
                end
            end

            if (finish) begin
                r_mask    <= n_mask;
                r_sink    <= n_sink;
                if (wr_en) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    assign o_out.valid             = r_o_valid;
    assign o_out.event_kind        = r_o_ev;
    assign o_out.newly_tainted_reg = r_o_reg;
    assign o_out.taint_mask        = r_o_mask;
    assign o_out.sink_seen         = r_o_sink;
    assign o_out.offset_store_full = r_o_full;

endmodule

/* verif/register_stack_taint_tracker_tb.sv */
module register_stack_taint_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rstt_pkg::*;

    localparam int STACK_SLOTS  = 16;
    localparam int RANDOM_ITEMS = 1850;
    localparam int POOL_SIZE    = 24;
    // Slowest item: a full slot walk, the longest sender gap and the longest sink
    // stall, on about 2000 items; allow many times that.
    localparam int CYCLE_LIMIT  = 400_000;
    // Wait at the end for twice the span of the longest item, a walk of all slots.
    localparam int TAIL_CYCLES  = 2 * (STACK_SLOTS + 3);

    // One lifted instruction as the feeder hands it over.
    typedef struct packed {
        t_op        op;
        t_reg_field dst_reg;
        t_reg_field src_a_reg;
        t_reg_field src_b_reg;
        t_offset    stack_offset;
        logic       source_call;
        logic       begin_run;
    } t_lifted_instr;

    // One taint result as the block reports it.
    typedef struct packed {
        t_event   kind;
        t_reg_idx new_reg;
        t_mask    mask;
        logic     sink;
        logic     dropped;
    } t_taint_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rstt_in_if  in_if ();
    rstt_out_if out_if ();

    register_stack_taint_tracker #(
        .STACK_SLOTS (STACK_SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the tracker state, advanced once per accepted word.
    t_mask   tracked_regs;
    t_offset slot_keys [STACK_SLOTS];
    int      slot_fill;
    logic    sink_reached;

    t_taint_result pending_results [$];
    int            mismatches;
    int            results_checked;
    int            cycle_count;
    logic          quiet_sender;
    logic          quiet_receiver;
    t_offset       offset_pool [POOL_SIZE];

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A register field names a real register only while its sign bit is clear,
    // so -32 (index bits all zero) must never alias X0.
    function automatic logic reg_is_tainted(t_reg_field f);
        return !f[5] && tracked_regs[f[4:0]];
    endfunction

    function automatic t_taint_result track_taint(t_lifted_instr w);
        t_taint_result r;
        logic          hit;
        r = '0;
        r.kind = EV_NONE;
        // The begin flag wipes everything before the word itself is handled.
        if (w.begin_run) begin
            tracked_regs = '0;
            slot_fill    = 0;
            sink_reached = 1'b0;
        end
        hit = 1'b0;
        for (int i = 0; i < slot_fill; i++) begin
            if (slot_keys[i] == w.stack_offset) begin
                hit = 1'b1;
            end
        end
        case (w.op)
            OP_BL: begin
                if (w.source_call) begin
                    tracked_regs[0] = 1'b1;
                    r.kind = EV_SOURCE;
                end
            end
            OP_STR: begin
                // For a store the destination field is the register written out.
                if (reg_is_tainted(w.dst_reg)) begin
                    r.kind = EV_STORE;
                    if (!hit) begin
                        if (slot_fill < STACK_SLOTS) begin
                            slot_keys[slot_fill] = w.stack_offset;
                            slot_fill++;
                        end else begin
                            r.dropped = 1'b1;
                        end
                    end
                end
            end
            OP_LDR: begin
                if (!w.dst_reg[5] && hit) begin
                    r.new_reg = w.dst_reg[4:0];
                    tracked_regs[w.dst_reg[4:0]] = 1'b1;
                    r.kind = EV_LOAD;
                end
            end
            OP_ADD, OP_SUB, OP_MOV: begin
                if (!w.dst_reg[5] &&
                    (reg_is_tainted(w.src_a_reg) || reg_is_tainted(w.src_b_reg))) begin
                    r.new_reg = w.dst_reg[4:0];
                    tracked_regs[w.dst_reg[4:0]] = 1'b1;
                    r.kind = EV_SPREAD;
                end
            end
            OP_RET: begin
                if (tracked_regs[0]) begin
                    sink_reached = 1'b1;
                    r.kind = EV_SINK;
                end
            end
            OP_OTHER: begin
                // Generic ops only look at the first source.
                if (!w.dst_reg[5] && reg_is_tainted(w.src_a_reg)) begin
                    r.new_reg = w.dst_reg[4:0];
                    tracked_regs[w.dst_reg[4:0]] = 1'b1;
                    r.kind = EV_GENERIC;
                end
            end
            default: begin
            end
        endcase
        r.mask = tracked_regs;
        r.sink = sink_reached;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    function automatic t_lifted_instr make_instr(t_op op, int dst, int src_a, int src_b,
                                                 t_offset off, logic src_call, logic clear);
        t_lifted_instr w;
        w.op           = op;
        w.dst_reg      = t_reg_field'(dst);
        w.src_a_reg    = t_reg_field'(src_a);
        w.src_b_reg    = t_reg_field'(src_b);
        w.stack_offset = off;
        w.source_call  = src_call;
        w.begin_run    = clear;
        return w;
    endfunction

    // Present one word after a random gap, hold it until taken, then queue its
    // predicted result. Every change lands on a falling edge.
    task automatic send_word(t_lifted_instr w);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.op           <= w.op;
        in_if.dst_reg      <= w.dst_reg;
        in_if.src_a_reg    <= w.src_a_reg;
        in_if.src_b_reg    <= w.src_b_reg;
        in_if.stack_offset <= w.stack_offset;
        in_if.source_call  <= w.source_call;
        in_if.begin_run    <= w.begin_run;
        in_if.valid        <= 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        pending_results = {pending_results, track_taint(w)};
    endtask

    // Drop valid and hold off until every queued result has come back.
    task automatic settle_results();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
        $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
                 $realtime, results_checked, field, want, got);
        mismatches++;
    endtask

    // Result sink: stall for a random span per word (none when quiet), then hold ready until
    // a word is taken.
    initial begin : result_sink
        int stall;
        out_if.ready <= 1'b0;
        forever begin
            stall = quiet_receiver ? 0 : $urandom_range(0, 3);
            repeat (stall) begin
                @(negedge i_clk);
                out_if.ready <= 1'b0;
            end
            @(negedge i_clk);
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    // Compare every accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        t_taint_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word, kind", '0, out_if.event_kind);
            end else begin
                want = pending_results.pop_front();
                if (out_if.event_kind !== want.kind)
                    report_mismatch("event_kind", want.kind, out_if.event_kind);
                if (out_if.newly_tainted_reg !== want.new_reg)
                    report_mismatch("newly_tainted_reg", want.new_reg,
                                    out_if.newly_tainted_reg);
                if (out_if.taint_mask !== want.mask)
                    report_mismatch("taint_mask", want.mask, out_if.taint_mask);
                if (out_if.sink_seen !== want.sink)
                    report_mismatch("sink_seen", want.sink, out_if.sink_seen);
                if (out_if.offset_store_full !== want.dropped)
                    report_mismatch("offset_store_full", want.dropped,
                                    out_if.offset_store_full);
            end
            results_checked++;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Source call, sink, source flag on a non-call, and the begin flag.
    task automatic test_source_and_sink();
        send_word(make_instr(OP_RET, -1, -1, -1, '0, 1'b0, 1'b0));
        send_word(make_instr(OP_BL, -1, -1, -1, '0, 1'b0, 1'b0));
        send_word(make_instr(OP_ADD, 5, 0, -1, '0, 1'b1, 1'b0));
        send_word(make_instr(OP_BL, -1, -1, -1, '0, 1'b1, 1'b0));
        send_word(make_instr(OP_RET, -1, -1, -1, '0, 1'b0, 1'b0));
        send_word(make_instr(OP_B, 3, 0, 0, '0, 1'b0, 1'b1));
    endtask

    // Spread through add, sub, mov and generic ops; negative register fields; ops with no rule.
    task automatic test_spread_rules();
        send_word(make_instr(OP_BL, -1, -1, -1, '0, 1'b1, 1'b1));
        send_word(make_instr(OP_ADD, 31, 0, -1, '0, 1'b0, 1'b0));
        send_word(make_instr(OP_SUB, 7, -1, 31, '0, 1'b0, 1'b0));
        // Sign bit set with index bits zero must not read X0.
        send_word(make_instr(OP_MOV, 3, -32, -32, '0, 1'b0, 1'b0));
        send_word(make_instr(OP_OTHER, 9, 5, 0, '0, 1'b0, 1'b0));
        send_word(make_instr(OP_OTHER, 9, 7, -1, '0, 1'b0, 1'b0));
        send_word(make_instr(OP_ADD, -1, 0, 0, '0, 1'b0, 1'b0));
        send_word(make_instr(OP_CBNZ, 12, 0, 0, '0, 1'b0, 1'b0));
        send_word(make_instr(OP_CBZ, 12, 0, 0, '0, 1'b0, 1'b0));
        send_word(make_instr(t_op'(15), 12, 0, 0, '0, 1'b1, 1'b0));
    endtask

    // Offset set: extremes, duplicates, loads, filling up and overflow.
    task automatic test_stack_slots();
        t_offset min_off;
        t_offset max_off;
        min_off = {1'b1, 63'd0};
        max_off = {1'b0, {63{1'b1}}};
        send_word(make_instr(OP_STR, 1, 31, -1, '0, 1'b0, 1'b0));
        send_word(make_instr(OP_STR, 0, 31, -1, min_off, 1'b0, 1'b0));
        send_word(make_instr(OP_STR, 31, 31, -1, max_off, 1'b0, 1'b0));
        send_word(make_instr(OP_STR, -32, 31, -1, 64'sd5, 1'b0, 1'b0));
        send_word(make_instr(OP_STR, 0, 31, -1, min_off, 1'b0, 1'b0));
        send_word(make_instr(OP_LDR, 20, 31, -1, max_off, 1'b0, 1'b0));
        send_word(make_instr(OP_LDR, 21, 31, -1, 64'sd1234, 1'b0, 1'b0));
        send_word(make_instr(OP_LDR, -1, 31, -1, min_off, 1'b0, 1'b0));
        // Fill the remaining slots, then push one more past the end.
        for (int k = 1; k <= STACK_SLOTS - 2; k++) begin
            send_word(make_instr(OP_STR, 7, 31, -1, -64'sd8 * k, 1'b0, 1'b0));
        end
        send_word(make_instr(OP_STR, 0, 31, -1, 64'sd4096, 1'b0, 1'b0));
        send_word(make_instr(OP_STR, 0, 31, -1, max_off, 1'b0, 1'b0));
        send_word(make_instr(OP_LDR, 30, 31, -1, -64'sd8 * (STACK_SLOTS - 2), 1'b0, 1'b0));
        send_word(make_instr(OP_RET, -1, -1, -1, -64'sd1, 1'b0, 1'b0));
    endtask

    function automatic t_reg_field pick_reg();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return t_reg_field'($urandom_range(0, 7));
        else if (r < 85)
            return t_reg_field'($urandom_range(0, 31));
        return t_reg_field'($urandom);
    endfunction

    // Mostly instructions that move taint around a small set of registers and
    // stack slots, with some raw noise mixed in.
    function automatic t_lifted_instr random_instr(logic clear);
        t_lifted_instr w;
        int            r;
        w.dst_reg     = pick_reg();
        w.src_a_reg   = pick_reg();
        w.src_b_reg   = pick_reg();
        w.source_call = ($urandom_range(0, 7) == 0);
        w.begin_run   = clear || ($urandom_range(0, 199) == 0);
        if ($urandom_range(0, 3) != 0)
            w.stack_offset = offset_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            w.stack_offset = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 12) begin
            w.op = OP_BL;
            w.source_call = ($urandom_range(0, 3) != 0);
        end else if (r < 30) begin
            w.op = OP_STR;
        end else if (r < 46) begin
            w.op = OP_LDR;
        end else if (r < 68) begin
            w.op = t_op'($urandom_range(OP_ADD, OP_MOV));
        end else if (r < 78) begin
            w.op = OP_OTHER;
        end else if (r < 87) begin
            w.op = OP_RET;
        end else begin
            w.op = t_op'($urandom_range(0, 15));
        end
        return w;
    endfunction

    // Runs of random length, each opened by the begin flag; flip between
    // idling and back-to-back traffic on both sides per run.
    task automatic test_random_runs();
        t_lifted_instr w;
        int            live_items;
        int            run_len;
        logic          drained;
        live_items = 0;
        drained    = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            offset_pool[i] = (i % 3 == 0) ? t_offset'({$urandom, $urandom})
                                          : -t_offset'(8 * i);
        end
        offset_pool[0] = {1'b1, 63'd0};
        offset_pool[1] = {1'b0, {63{1'b1}}};
        offset_pool[2] = '0;
        offset_pool[3] = '1;
        while (live_items < RANDOM_ITEMS) begin
            run_len        = $urandom_range(20, 120);
            quiet_sender   = ($urandom_range(0, 3) == 0);
            quiet_receiver = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < run_len; k++) begin
                w = random_instr(k == 0);
                send_word(w);
                live_items++;
            end
            // Hold off once midway until the block has drained.
            if (!drained && live_items >= RANDOM_ITEMS / 2) begin
                settle_results();
                drained = 1'b1;
            end
        end
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        tracked_regs       = '0;
        slot_fill          = 0;
        sink_reached       = 1'b0;
        mismatches         = 0;
        results_checked    = 0;
        cycle_count        = 0;
        quiet_sender       = 1'b0;
        quiet_receiver     = 1'b0;
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.op           = OP_ADD;
        in_if.dst_reg      = '0;
        in_if.src_a_reg    = '0;
        in_if.src_b_reg    = '0;
        in_if.stack_offset = '0;
        in_if.source_call  = 1'b0;
        in_if.begin_run    = 1'b0;

        // Hold reset low, then release it on a falling edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_source_and_sink();
        settle_results();
        test_spread_rules();
        settle_results();
        test_stack_slots();
        settle_results();
        test_random_runs();

        // Drop valid, drain the queue, then give stray words time to show up.
        settle_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
